// ----- design/chm_pkg.sv -----
// Shared types and constants of the chained hash map.
package chm_pkg;
    localparam int BUCKETS_DEF = 256;
    localparam int ENTRIES_DEF = 1024;
    localparam int CFG_W       = 9;
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;
    localparam int BKT_MAX_W   = 16;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] REG_BUCKET_COUNT = 2'd0;

    typedef struct packed {
        logic [1:0]           action;
        logic [KEY_W-1:0]     key;
        logic [VAL_W-1:0]     new_value;
        logic [BKT_MAX_W-1:0] bucket;
    } t_req;
endpackage

// ----- design/chm_front.sv -----
// Request intake: bit-serial bucket computation (key modulo bucket count).
module chm_front #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_action,
    input  logic [chm_pkg::KEY_W-1:0] i_key,
    input  logic [chm_pkg::VAL_W-1:0] i_new_value,
    input  logic [chm_pkg::CFG_W-1:0] i_bucket_count,
    output logic                      o_push,
    output chm_pkg::t_req             o_req,
    input  logic                      i_full
);
    localparam int CW = chm_pkg::CFG_W;

    logic                       r_busy, r_calc;
    logic [4:0]                 r_bit;
    logic [CW-1:0]              r_rem;
    logic [1:0]                 r_act;
    logic [chm_pkg::KEY_W-1:0]  r_key;
    logic [chm_pkg::VAL_W-1:0]  r_val;
    logic [CW-1:0]              m;
    logic [CW:0]                t;
    logic [CW-1:0]              n_rem;

    always_comb begin
        if (i_bucket_count == '0) begin
            m = CW'(1);
        end else if (32'(i_bucket_count) > BUCKETS) begin
            m = CW'(BUCKETS);
        end else begin
            m = i_bucket_count;
        end
        t = {r_rem, r_key[r_bit]};
        if (t >= {1'b0, m}) begin
            n_rem = CW'(t - {1'b0, m});
        end else begin
            n_rem = t[CW-1:0];
        end
    end

    assign o_ready = !r_busy && i_rst_n;
    assign o_push  = r_busy && !r_calc && !i_full;
    assign o_req   = '{action: r_act, key: r_key, new_value: r_val,
                       bucket: chm_pkg::BKT_MAX_W'(r_rem)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_calc <= 1'b0;
        end else if (!r_busy) begin
            if (i_valid) begin
                r_busy <= 1'b1;
                r_calc <= 1'b1;
            end
        end else if (r_calc) begin
            if (r_bit == '0) begin
                r_calc <= 1'b0;
            end
        end else if (!i_full) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) begin
            r_act <= i_action;
            r_key <= i_key;
            r_val <= i_new_value;
            r_rem <= '0;
            r_bit <= 5'(chm_pkg::KEY_W - 1);
        end else if (r_busy && r_calc) begin
            r_rem <= n_rem;
            r_bit <= r_bit - 5'd1;
        end
    end
endmodule

// ----- design/chm_queue.sv -----
// Two-entry request queue between intake and execution.
module chm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  chm_pkg::t_req i_req,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output chm_pkg::t_req o_req
);
    chm_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= !r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && o_valid) ? 1 : 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wp] <= i_req;
        end
    end
endmodule

// ----- design/chm_back.sv -----
// Request execution: chain walk, insert, unlink, free list and result register.
module chm_back #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chm_pkg::ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  chm_pkg::t_req             i_req,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [chm_pkg::VAL_W-1:0] o_found_value
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW = $clog2(ENTRIES);
    localparam int PW = IW + 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_HEAD     = 9'b000000010,
        S_INS_LNK  = 9'b000000100,
        S_INS_WR   = 9'b000001000,
        S_INS_TAIL = 9'b000010000,
        S_READ     = 9'b000100000,
        S_CMP      = 9'b001000000,
        S_DEL_LNK  = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state r_state;

    logic [PW-1:0]             head_mem [BUCKETS];
    logic                      r_hvalid [BUCKETS];
    logic [IW-1:0]             tail_mem [BUCKETS];
    logic [chm_pkg::KEY_W-1:0] key_mem  [ENTRIES];
    logic [chm_pkg::VAL_W-1:0] val_mem  [ENTRIES];
    logic [PW-1:0]             link_mem [ENTRIES];

    logic [PW-1:0]             r_head_rd, r_link_rd;
    logic                      r_hv_rd;
    logic [IW-1:0]             r_tail_rd;
    logic [chm_pkg::KEY_W-1:0] r_key_rd;
    logic [chm_pkg::VAL_W-1:0] r_val_rd;

    logic [1:0]                r_act, r_status;
    logic [chm_pkg::KEY_W-1:0] r_key;
    logic [chm_pkg::VAL_W-1:0] r_val, r_found;
    logic [BW-1:0]             r_bkt;
    logic [PW-1:0]             r_head, r_cur, r_prev, r_rec, r_fresh;
    logic [IW-1:0]             r_tail, r_slot;
    logic                      r_from_rec;

    logic                      out_free, match;
    logic [BW-1:0]             bkt_addr;
    logic [IW-1:0]             e_addr;
    logic                      head_we, tail_we, link_we, entry_we;
    logic [PW-1:0]             head_wd, link_wd;
    logic [IW-1:0]             tail_wd, link_wa;

    assign out_free = !o_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign bkt_addr = (r_state == S_IDLE) ? BW'(i_req.bucket) : r_bkt;
    assign e_addr   = (r_state == S_INS_LNK) ? r_slot : r_cur[IW-1:0];
    assign match    = (r_key_rd == r_key);

    always_comb begin
        head_we  = 1'b0;
        head_wd  = r_link_rd;
        tail_we  = 1'b0;
        tail_wd  = r_slot;
        link_we  = 1'b0;
        link_wa  = r_slot;
        link_wd  = NULL_PTR;
        entry_we = 1'b0;
        case (r_state)
            S_INS_WR: begin
                entry_we = 1'b1;
                link_we  = 1'b1;
                tail_we  = 1'b1;
                if (r_head == NULL_PTR) begin
                    head_we = 1'b1;
                    head_wd = PW'(r_slot);
                end
            end
            S_INS_TAIL: begin
                link_we = 1'b1;
                link_wa = r_tail;
                link_wd = PW'(r_slot);
            end
            S_CMP: begin
                if (match && r_act == chm_pkg::ACT_DELETE) begin
                    if (r_prev != NULL_PTR) begin
                        link_we = 1'b1;
                        link_wa = r_prev[IW-1:0];
                        link_wd = r_link_rd;
                    end else begin
                        head_we = 1'b1;
                    end
                    if (PW'(r_tail) == r_cur) begin
                        tail_we = 1'b1;
                        tail_wd = (r_prev != NULL_PTR) ? r_prev[IW-1:0] : '0;
                    end
                end
            end
            S_DEL_LNK: begin
                link_we = 1'b1;
                link_wa = r_cur[IW-1:0];
                link_wd = r_rec;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_head_rd <= head_mem[bkt_addr];
        r_tail_rd <= tail_mem[bkt_addr];
        r_key_rd  <= key_mem[e_addr];
        r_val_rd  <= val_mem[e_addr];
        r_link_rd <= link_mem[e_addr];
        if (head_we) begin
            head_mem[r_bkt] <= head_wd;
        end
        if (tail_we) begin
            tail_mem[r_bkt] <= tail_wd;
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (entry_we) begin
            key_mem[r_slot] <= r_key;
            val_mem[r_slot] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUCKETS; i++) begin
                r_hvalid[i] <= 1'b0;
            end
            r_hv_rd <= 1'b0;
        end else begin
            r_hv_rd <= r_hvalid[bkt_addr];
            if (head_we) begin
                r_hvalid[r_bkt] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rec   <= NULL_PTR;
            r_fresh <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    if (r_act == chm_pkg::ACT_INSERT) begin
                        if (r_rec != NULL_PTR) begin
                            r_state <= S_INS_LNK;
                        end else if (r_fresh != NULL_PTR) begin
                            r_fresh <= r_fresh + PW'(1);
                            r_state <= S_INS_WR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (r_act == chm_pkg::ACT_LOOKUP ||
                                 r_act == chm_pkg::ACT_DELETE) begin
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_INS_LNK: r_state <= S_INS_WR;
                S_INS_WR: begin
                    if (r_from_rec) begin
                        r_rec <= r_link_rd;
                    end
                    r_state <= (r_head == NULL_PTR) ? S_DONE : S_INS_TAIL;
                end
                S_INS_TAIL: r_state <= S_DONE;
                S_READ: r_state <= (r_cur == NULL_PTR) ? S_DONE : S_CMP;
                S_CMP: begin
                    if (!match) begin
                        r_state <= S_READ;
                    end else if (r_act == chm_pkg::ACT_DELETE) begin
                        r_state <= S_DEL_LNK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DEL_LNK: begin
                    r_rec   <= r_cur;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_act <= i_req.action;
                r_key <= i_req.key;
                r_val <= i_req.new_value;
                r_bkt <= BW'(i_req.bucket);
            end
            S_HEAD: begin
                r_head     <= r_hv_rd ? r_head_rd : NULL_PTR;
                r_cur      <= r_hv_rd ? r_head_rd : NULL_PTR;
                r_tail     <= r_tail_rd;
                r_prev     <= NULL_PTR;
                r_found    <= '0;
                r_from_rec <= (r_rec != NULL_PTR);
                r_slot     <= (r_rec != NULL_PTR) ? r_rec[IW-1:0] : r_fresh[IW-1:0];
                if (r_act == chm_pkg::ACT_INSERT) begin
                    r_status <= (r_rec == NULL_PTR && r_fresh == NULL_PTR)
                                ? chm_pkg::ST_FULL : chm_pkg::ST_OK;
                end else begin
                    r_status <= chm_pkg::ST_MISS;
                end
            end
            S_CMP: begin
                if (match) begin
                    r_status <= chm_pkg::ST_OK;
                    if (r_act == chm_pkg::ACT_LOOKUP) begin
                        r_found <= r_val_rd;
                    end
                end else begin
                    r_prev <= r_cur;
                    r_cur  <= r_link_rd;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_status      <= r_status;
                    o_found_value <= r_found;
                end
            end
            default: begin
            end
        endcase
    end

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NULL_PTR)
        else $error("fresh slot count past pool size");
    a_full_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == chm_pkg::ST_FULL) |->
        (r_rec == NULL_PTR && r_fresh == NULL_PTR && r_act == chm_pkg::ACT_INSERT))
        else $error("pool full reported with free slots");
    a_found_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_found != '0) |->
        (r_act == chm_pkg::ACT_LOOKUP && r_status == chm_pkg::ST_OK))
        else $error("value returned outside a successful lookup");
endmodule

// ----- design/chained_hash_map.sv -----
// Chained hash map top level: stream request/result ports and APB register.
// In the intake the bucket is worked out one key bit a cycle by a restoring
// remainder against the bucket count; the next request's bucket is computed
// while the executor handles the current one, and a two-entry queue sits
// between them. An insert reads the bucket head, takes a recycled slot (reading
// its link first) or a never-used one, writes the entry and, when the chain
// already holds entries, links it behind the tail. A lookup or delete walks the
// chain; each chain step is one registered read of the entry memories and a
// key compare, and a delete unlinks the entry and puts its slot on the free
// list. A stalled result holds the executor in its done state. No clearing
// pass is needed after reset: bucket heads carry valid bits and never-used
// slots are handed out by a counter.
module chained_hash_map #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chm_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // action[1:0], key[32:2], new_value[64:33]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // status[1:0], found_value[33:2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = chm_pkg::CFG_W;

    logic [CW-1:0]             r_bucket_count;
    logic                      push, full, pop, q_valid;
    chm_pkg::t_req             f_req, q_req;
    logic [1:0]                status;
    logic [chm_pkg::VAL_W-1:0] found_value;

    assign pready = 1'b1;
    assign prdata = (paddr == chm_pkg::REG_BUCKET_COUNT)
                    ? 32'(r_bucket_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CW'((BUCKETS < 256) ? BUCKETS : 256);
        end else if (psel && penable && pwrite && pready &&
                     paddr == chm_pkg::REG_BUCKET_COUNT) begin
            r_bucket_count <= pwdata[CW-1:0];
        end
    end

    chm_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_action       (i_s_axis_tdata[1:0]),
        .i_key          (i_s_axis_tdata[32:2]),
        .i_new_value    (i_s_axis_tdata[64:33]),
        .i_bucket_count (r_bucket_count),
        .o_push         (push),
        .o_req          (f_req),
        .i_full         (full)
    );

    chm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    chm_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_req         (q_req),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_status      (status),
        .o_found_value (found_value)
    );

    assign o_m_axis_tdata = {6'd0, found_value, status};
endmodule
